>>> hdl/accel_multi_tap_detector_macros.svh
// Assertion macros used by the tap detector checker.
`ifndef ACCEL_MULTI_TAP_DETECTOR_MACROS_SVH
`define ACCEL_MULTI_TAP_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tap detector assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tap detector assertion failed");

`endif

>>> hdl/mtd_pkg.sv
// Shared types and constants of the multi-tap detector.
package mtd_pkg;

  localparam int unsigned THR_W      = 15;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned EVT_TIME_W = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Base level = prev + jump * BASE_NUM / 2^BASE_SHIFT (0.9 in fixed point)
  localparam int unsigned BASE_NUM   = 230;
  localparam int unsigned BASE_SHIFT = 8;

  localparam logic [CNT_W-1:0] TAP_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_THRESHOLD    = 3'd0,
    REG_RISE_WINDOW_MS   = 3'd1,
    REG_QUIET_TIMEOUT_MS = 3'd2,
    REG_MIN_TAPS         = 3'd3,
    REG_MAX_TAPS         = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0] tap_threshold;
    logic [WIN_W-1:0] rise_window_ms;
    logic [WIN_W-1:0] quiet_timeout_ms;
    logic [CNT_W-1:0] min_taps;
    logic [CNT_W-1:0] max_taps;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tap_threshold:    15'd1280,
    rise_window_ms:   16'd80,
    quiet_timeout_ms: 16'd2000,
    min_taps:         8'd2,
    max_taps:         8'd5
  };

endpackage

>>> hdl/mtd_if.sv
// Sample and event channel interfaces of the multi-tap detector.
interface mtd_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] z_sample;
  logic [TIME_WIDTH-1:0]          sample_time_ms;
  logic [TIME_WIDTH-1:0]          batch_time_ms;
  logic                           last_in_batch;

  modport source (output valid, z_sample, sample_time_ms, batch_time_ms, last_in_batch,
                  input ready);
  modport sink   (input valid, z_sample, sample_time_ms, batch_time_ms, last_in_batch,
                  output ready);
endinterface

interface mtd_event_if;
  logic                          valid;
  logic                          ready;
  logic [mtd_pkg::EVT_TIME_W-1:0] event_time_ms;
  logic [mtd_pkg::CNT_W-1:0]      tap_count;

  modport source (output valid, event_time_ms, tap_count, input ready);
  modport sink   (input valid, event_time_ms, tap_count, output ready);
endinterface

>>> hdl/mtd_cfg.sv
// Configuration register file of the multi-tap detector.
module mtd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output mtd_pkg::cfg_t                    cfg_o
);
  import mtd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_THRESHOLD:    cfg_q.tap_threshold    <= cfg_wdata_i[THR_W-1:0];
        REG_RISE_WINDOW_MS:   cfg_q.rise_window_ms   <= cfg_wdata_i[WIN_W-1:0];
        REG_QUIET_TIMEOUT_MS: cfg_q.quiet_timeout_ms <= cfg_wdata_i[WIN_W-1:0];
        REG_MIN_TAPS:         cfg_q.min_taps         <= cfg_wdata_i[CNT_W-1:0];
        REG_MAX_TAPS:         cfg_q.max_taps         <= cfg_wdata_i[CNT_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/mtd_detect.sv
// Per-sample tap detection: gesture state and its update on each step.
module mtd_detect #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  mtd_pkg::cfg_t                      cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     z_i,
  input  logic [TIME_WIDTH-1:0]              t_i,
  input  logic [TIME_WIDTH-1:0]              batch_i,
  input  logic                               last_i,
  output logic                               hit_o,
  output logic [mtd_pkg::EVT_TIME_W-1:0]     evt_time_o,
  output logic [mtd_pkg::CNT_W-1:0]          count_o
);
  import mtd_pkg::*;

  localparam int unsigned DW    = SAMPLE_WIDTH + 1;  // sample difference
  localparam int unsigned PW    = DW + BASE_SHIFT;   // scaled jump product
  localparam int unsigned CMP_W = DW + THR_W;
  localparam logic signed [PW-1:0] BASE_NUM_S = PW'(BASE_NUM);

  logic                           armed_q,  armed_d;
  logic [TIME_WIDTH-1:0]          rise_time_q, rise_time_d;
  logic signed [SAMPLE_WIDTH-1:0] base_q,   base_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic [CNT_W-1:0]               taps_q,   taps_d;
  logic                           lt_valid_q, lt_valid_d;
  logic [TIME_WIDTH-1:0]          lt_time_q,  lt_time_d;

  logic signed [DW-1:0] dev, jump;
  logic [DW-1:0]        dev_mag, jump_mag;
  logic                 dev_big, jump_big, in_window, tap_now, quiet, report;
  logic signed [PW-1:0] prod, scaled, base_sum;
  logic [TIME_WIDTH-1:0] rise_age, quiet_age, lt_time_mid;
  logic [CNT_W-1:0]     taps_mid;
  logic                 lt_valid_mid;

  always_comb begin
    dev      = DW'(z_i) - DW'(base_q);
    jump     = DW'(z_i) - DW'(prev_q);
    dev_mag  = dev[DW-1]  ? DW'(-dev)  : DW'(dev);
    jump_mag = jump[DW-1] ? DW'(-jump) : DW'(jump);
    dev_big  = CMP_W'(dev_mag)  > CMP_W'(cfg_i.tap_threshold);
    jump_big = CMP_W'(jump_mag) > CMP_W'(cfg_i.tap_threshold);

    // floor(0.9 * jump) via arithmetic shift, rounds toward minus infinity
    prod     = PW'(jump) * BASE_NUM_S;
    scaled   = prod >>> BASE_SHIFT;
    base_sum = PW'(prev_q) + scaled;

    rise_age  = t_i - rise_time_q;
    in_window = rise_age < TIME_WIDTH'(cfg_i.rise_window_ms);
    tap_now   = armed_q && in_window && dev_big;

    armed_d     = armed_q ? (in_window && !dev_big) : jump_big;
    rise_time_d = (!armed_q && jump_big) ? t_i : rise_time_q;
    base_d      = (!armed_q && jump_big) ? SAMPLE_WIDTH'(base_sum) : base_q;

    lt_valid_mid = lt_valid_q || tap_now;
    lt_time_mid  = tap_now ? batch_i : lt_time_q;
    taps_mid     = (tap_now && taps_q != TAP_MAX) ? taps_q + CNT_W'(1) : taps_q;

    quiet_age = batch_i - lt_time_mid;
    quiet     = quiet_age > TIME_WIDTH'(cfg_i.quiet_timeout_ms);
    report    = last_i && lt_valid_mid && quiet;

    hit_o      = report && taps_mid >= cfg_i.min_taps && taps_mid <= cfg_i.max_taps;
    evt_time_o = EVT_TIME_W'(batch_i);
    count_o    = taps_mid;

    taps_d     = report ? '0 : taps_mid;
    lt_valid_d = report ? 1'b0 : lt_valid_mid;
    lt_time_d  = report ? '0 : lt_time_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      rise_time_q <= '0;
      base_q      <= '0;
      prev_q      <= '0;
      taps_q      <= '0;
      lt_valid_q  <= 1'b0;
      lt_time_q   <= '0;
    end else if (step_i) begin
      armed_q     <= armed_d;
      rise_time_q <= rise_time_d;
      base_q      <= base_d;
      prev_q      <= z_i;
      taps_q      <= taps_d;
      lt_valid_q  <= lt_valid_d;
      lt_time_q   <= lt_time_d;
    end
  end

endmodule

>>> hdl/accel_multi_tap_detector.sv
// Top level of the Z-axis multi-tap gesture detector.
//
// Usage:
//   smp_i  - sample requests: z_sample, sample_time_ms, batch_time_ms, last_in_batch.
//   evt_o  - gesture requests: event_time_ms (batch time) and tap_count.
//   cfg_*  - register writes (threshold, rise window, quiet timeout, min/max taps);
//            write only while no sample is in flight.
// Path: the sample that completes a gesture passes the input register, then the
//   result register, whose request shows on evt_o.
// Throughput: one sample per cycle while evt_o is not held off; the detect state
//   updates as each sample steps, so consecutive samples stream without bubbles.
// Only the last sample of a batch can produce a request; at most one per sample.
// Reset: all detect state clears, registers take their defaults, both
//   channels go empty.
// Stall: while evt_o is held off, the result register keeps its request and the
//   input register can still take one more sample; further samples wait.
module accel_multi_tap_detector #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mtd_sample_if.sink                       smp_i,
  mtd_event_if.source                      evt_o
);
  import mtd_pkg::*;

  cfg_t cfg;

  // input register stage
  logic                           s1_v_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_z_q;
  logic [TIME_WIDTH-1:0]          s1_t_q;
  logic [TIME_WIDTH-1:0]          s1_batch_q;
  logic                           s1_last_q;

  // result register stage
  logic                   out_v_q;
  logic [EVT_TIME_W-1:0]  out_time_q;
  logic [CNT_W-1:0]       out_cnt_q;

  logic                  adv, in_ready, step, hit;
  logic [EVT_TIME_W-1:0] hit_time;
  logic [CNT_W-1:0]      hit_cnt;

  // result slot is free or being drained this cycle
  assign adv      = !out_v_q || evt_o.ready;
  assign in_ready = !s1_v_q || adv;
  assign step     = s1_v_q && adv;

  mtd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mtd_detect #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cfg_i      (cfg),
    .z_i        (s1_z_q),
    .t_i        (s1_t_q),
    .batch_i    (s1_batch_q),
    .last_i     (s1_last_q),
    .hit_o      (hit),
    .evt_time_o (hit_time),
    .count_o    (hit_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_q <= smp_i.valid;
      end
      if (adv) begin
        out_v_q <= step && hit;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready && smp_i.valid) begin
      s1_z_q     <= smp_i.z_sample;
      s1_t_q     <= smp_i.sample_time_ms;
      s1_batch_q <= smp_i.batch_time_ms;
      s1_last_q  <= smp_i.last_in_batch;
    end
    if (step && hit) begin
      out_time_q <= hit_time;
      out_cnt_q  <= hit_cnt;
    end
  end

  assign smp_i.ready         = in_ready;
  assign evt_o.valid         = out_v_q;
  assign evt_o.event_time_ms = out_time_q;
  assign evt_o.tap_count     = out_cnt_q;

endmodule

>>> hdl/mtd_checker.sv
// Port-level assertion checker for the multi-tap detector, with its bind.
`include "accel_multi_tap_detector_macros.svh"

module mtd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           smp_valid_i,
  input logic                           smp_ready_i,
  input logic                           evt_valid_i,
  input logic                           evt_ready_i,
  input logic [mtd_pkg::EVT_TIME_W-1:0] evt_time_i,
  input logic [mtd_pkg::CNT_W-1:0]      evt_count_i
);
  import mtd_pkg::*;

  logic smp_acc;
  assign smp_acc = smp_valid_i && smp_ready_i;

  // a stalled request keeps its payload
  `MTD_ASSERT_NXT(a_evt_hold, clk_i, rst_ni, evt_valid_i && !evt_ready_i,
                  evt_valid_i && $stable(evt_time_i) && $stable(evt_count_i))

  // a reported gesture always holds at least one tap
  `MTD_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, evt_valid_i, evt_count_i != '0)

  // a fresh request must trace back to an earlier accepted sample
  `MTD_ASSERT_IMP(a_evt_from_sample, clk_i, rst_ni, $rose(evt_valid_i), $past(smp_acc, 2))

  // with the result slot empty, samples are never held off
  `MTD_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !evt_valid_i, smp_ready_i)

endmodule

bind accel_multi_tap_detector mtd_checker u_mtd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .evt_valid_i (evt_o.valid),
  .evt_ready_i (evt_o.ready),
  .evt_time_i  (evt_o.event_time_ms),
  .evt_count_i (evt_o.tap_count)
);
